// ----- src/wpcs_pkg.sv -----
// Shared types and constants for the window peak coverage search block.
`timescale 1ns / 1ps
package wpcs_pkg;

  localparam int unsigned DAY_W   = 11;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 56;

  localparam logic CFG_NUM_DAYS   = 1'b0;
  localparam logic CFG_WINDOW_LEN = 1'b1;

  localparam logic MODE_JOB  = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_JOB_WR,
    ST_EV_RD,
    ST_EV_CALC,
    ST_POP,
    ST_POP_WAIT,
    ST_HEAD,
    ST_HEAD_WAIT,
    ST_EVAL,
    ST_FIN
  } wpcs_state_e;

  typedef struct packed {
    logic job_rd;
    logic job_wr;
    logic sweep;
  } mark_cmd_t;

endpackage

// ----- src/wpcs_marks.sv -----
// Start and end mark memories with saturating updates and read-and-clear sweeps.
`timescale 1ns / 1ps
module wpcs_marks import wpcs_pkg::*; #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned CNT_W  = 16
) (
  input  logic              clk_i,
  input  mark_cmd_t         cmd_i,
  input  logic [ADDR_W-1:0] job_start_i,
  input  logic [ADDR_W-1:0] job_end_i,
  input  logic [ADDR_W-1:0] sweep_addr_i,
  output logic [CNT_W-1:0]  start_o,
  output logic [CNT_W-1:0]  end_o
);

  logic [CNT_W-1:0]  s_mem [DEPTH];
  logic [CNT_W-1:0]  e_mem [DEPTH];
  logic [CNT_W-1:0]  s_rd_q, e_rd_q;
  logic [ADDR_W-1:0] sa_q, ea_q;
  logic [ADDR_W-1:0] s_raddr, e_raddr, s_waddr, e_waddr;
  logic [CNT_W-1:0]  s_wdata, e_wdata;
  logic              rd_en, we;

  always_comb begin
    rd_en   = cmd_i.job_rd | cmd_i.sweep;
    we      = cmd_i.job_wr | cmd_i.sweep;
    s_raddr = cmd_i.job_rd ? job_start_i : sweep_addr_i;
    e_raddr = cmd_i.job_rd ? job_end_i : sweep_addr_i;
    s_waddr = cmd_i.job_wr ? sa_q : sweep_addr_i;
    e_waddr = cmd_i.job_wr ? ea_q : sweep_addr_i;
    s_wdata = '0;
    e_wdata = '0;
    if (cmd_i.job_wr) begin
      s_wdata = (s_rd_q == {CNT_W{1'b1}}) ? s_rd_q : s_rd_q + CNT_W'(1);
      e_wdata = (e_rd_q == {CNT_W{1'b1}}) ? e_rd_q : e_rd_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s_rd_q <= s_mem[s_raddr];
      e_rd_q <= e_mem[e_raddr];
    end
    if (cmd_i.job_rd) begin
      sa_q <= job_start_i;
      ea_q <= job_end_i;
    end
    if (we) begin
      s_mem[s_waddr] <= s_wdata;
      e_mem[e_waddr] <= e_wdata;
    end
  end

  assign start_o = s_rd_q;
  assign end_o   = e_rd_q;

endmodule

// ----- src/wpcs_deque.sv -----
// Storage for the monotonic peak queue: one write port and one registered read port.
`timescale 1ns / 1ps
module wpcs_deque #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 26
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/window_peak_coverage_search.sv -----
// Top level of the window peak coverage search block.
// Usage: job items (tuser 0) carry a one-based day interval in tdata and
// mark it in the start and end mark memories; a job reads both marks and
// then writes them back incremented. A job outside the day count or reversed
// marks nothing and is flagged. An evaluate item (tuser 1) produces one
// result item and no other item does. Evaluation walks every day up to the
// larger of num_days and the highest day marked since the last evaluation,
// reading and clearing the marks, building coverage as a running sum and
// keeping the window peak in a monotonic queue held in memory. Each day in
// the day count goes through the read, calculate, pop, head and evaluate
// states, plus a wait state per queue entry dropped unless the drop empties
// the queue and another when the queue front moves on to an entry held in
// memory; other days, and every day of a window that is too long, go only
// through the read and calculate states. The result register is loaded in
// the final state after the walk. The input side is ready only in the idle
// state. The result waits in an output register, so jobs keep being taken
// while the receiver stalls; a second evaluation holds in its final state
// until it is free. Reset clears all marks before any item is taken.
// Configuration writes are taken at any time and must be made while idle.
`timescale 1ns / 1ps
module window_peak_coverage_search import wpcs_pkg::*; #(
  parameter int unsigned MAX_DAYS   = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [DAY_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // first_day [10:0], last_day [21:11], zero fill [23:22]
  input  logic [IN_W-1:0]  s_axis_tdata,
  // mode [0]
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // busiest_start [10:0], quietest_start [21:11], busiest_level [37:22],
  // quietest_level [53:38], window_too_long [54], job_rejected [55]
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned ADDR_W = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_DAYS + 1);
  localparam int unsigned CB     = COUNT_BITS;

  wpcs_state_e state_q, state_d;

  logic [DAY_W-1:0]   num_days_q, num_days_d, window_len_q, window_len_d;
  logic [CNT_W-1:0]   i_q, i_d, head_q, head_d, tail_q, tail_d, hwm_q, hwm_d;
  logic [CB-1:0]      run_q, run_d, cov_q, cov_d;
  logic [ADDR_W-1:0]  back_idx_q, back_idx_d, front_idx_q, front_idx_d;
  logic [CB-1:0]      back_val_q, back_val_d, front_val_q, front_val_d;
  logic               found_q, found_d, too_long_q, too_long_d, rej_q, rej_d;
  logic [CB-1:0]      best_lvl_q, best_lvl_d, quiet_lvl_q, quiet_lvl_d;
  logic [DAY_W-1:0]   best_start_q, best_start_d, quiet_start_q, quiet_start_d;
  logic               m_valid_q, m_valid_d;
  logic [OUT_W-1:0]   m_data_q, m_data_d;

  logic [31:0]        n_eff, w_eff, f_day, l_day, sweep_end, win_start;
  logic               job_bad, peak_ok;
  logic [DAY_W-1:0]   first_day, last_day;
  logic [CB:0]        cov_sum;
  logic [CB-1:0]      cov_new;
  logic [LEVEL_W-1:0] best_out, quiet_out;

  mark_cmd_t          mark_cmd;
  logic [ADDR_W-1:0]  job_start_addr, job_end_addr;
  logic [CB-1:0]      start_mark, end_mark;

  logic               dq_we, dq_re;
  logic [ADDR_W-1:0]  dq_waddr, dq_raddr;
  logic [ADDR_W+CB-1:0] dq_wdata, dq_rdata;

  assign first_day = s_axis_tdata[DAY_W-1:0];
  assign last_day  = s_axis_tdata[2*DAY_W-1:DAY_W];

  always_comb begin
    if (num_days_q == '0) begin
      n_eff = 32'd1;
    end else if (32'(num_days_q) > MAX_DAYS) begin
      n_eff = MAX_DAYS;
    end else begin
      n_eff = 32'(num_days_q);
    end
    w_eff     = (window_len_q == '0) ? 32'd1 : 32'(window_len_q);
    f_day     = 32'(first_day);
    l_day     = 32'(last_day);
    job_bad   = (f_day == 32'd0) || (l_day == 32'd0) || (f_day > n_eff) ||
                (l_day > n_eff) || (f_day > l_day);
    sweep_end = (32'(hwm_q) > n_eff) ? 32'(hwm_q) : n_eff;
    win_start = 32'(i_q) + 32'd2 - w_eff;
    peak_ok   = (32'(i_q) + 32'd1) >= w_eff;
    cov_sum   = {1'b0, run_q} + {1'b0, start_mark};
    cov_new   = cov_sum[CB] ? {CB{1'b1}} : cov_sum[CB-1:0];
    best_out  = (33'(best_lvl_q) > 33'h0FFFF) ? 16'hFFFF : LEVEL_W'(best_lvl_q);
    quiet_out = (33'(quiet_lvl_q) > 33'h0FFFF) ? 16'hFFFF : LEVEL_W'(quiet_lvl_q);
    job_start_addr = ADDR_W'(f_day - 32'd1);
    job_end_addr   = ADDR_W'(l_day - 32'd1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR: begin
        if (32'(i_q) == MAX_DAYS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == MODE_EVAL) begin
            state_d = ST_EV_RD;
          end else if (!job_bad) begin
            state_d = ST_JOB_WR;
          end
        end
      end
      ST_JOB_WR: state_d = ST_IDLE;
      ST_EV_RD: state_d = ST_EV_CALC;
      ST_EV_CALC: begin
        if (too_long_q || 32'(i_q) >= n_eff) begin
          state_d = (32'(i_q) + 32'd1 < sweep_end) ? ST_EV_RD : ST_FIN;
        end else begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (tail_q > head_q && back_val_q <= cov_q) begin
          if (tail_q - CNT_W'(1) > head_q) begin
            state_d = ST_POP_WAIT;
          end
        end else begin
          state_d = ST_HEAD;
        end
      end
      ST_POP_WAIT: state_d = ST_POP;
      ST_HEAD: begin
        if (32'(front_idx_q) + w_eff <= 32'(i_q) &&
            head_q + CNT_W'(1) != tail_q - CNT_W'(1)) begin
          state_d = ST_HEAD_WAIT;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_HEAD_WAIT: state_d = ST_EVAL;
      ST_EVAL: state_d = (32'(i_q) + 32'd1 < sweep_end) ? ST_EV_RD : ST_FIN;
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    num_days_d    = num_days_q;
    window_len_d  = window_len_q;
    i_d           = i_q;
    head_d        = head_q;
    tail_d        = tail_q;
    hwm_d         = hwm_q;
    run_d         = run_q;
    cov_d         = cov_q;
    back_idx_d    = back_idx_q;
    back_val_d    = back_val_q;
    front_idx_d   = front_idx_q;
    front_val_d   = front_val_q;
    found_d       = found_q;
    too_long_d    = too_long_q;
    rej_d         = rej_q;
    best_lvl_d    = best_lvl_q;
    quiet_lvl_d   = quiet_lvl_q;
    best_start_d  = best_start_q;
    quiet_start_d = quiet_start_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_data_d      = m_data_q;
    mark_cmd      = '0;
    dq_we         = 1'b0;
    dq_re         = 1'b0;
    dq_waddr      = tail_q[ADDR_W-1:0];
    dq_wdata      = {i_q[ADDR_W-1:0], cov_q};
    dq_raddr      = tail_q[ADDR_W-1:0];
    s_axis_tready = (state_q == ST_IDLE);

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_NUM_DAYS:   num_days_d   = cfg_wdata_i;
        CFG_WINDOW_LEN: window_len_d = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_CLR: begin
        mark_cmd.sweep = 1'b1;
        i_d = i_q + CNT_W'(1);
        if (32'(i_q) == MAX_DAYS - 1) begin
          i_d = '0;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == MODE_EVAL) begin
            i_d         = '0;
            head_d      = '0;
            tail_d      = '0;
            run_d       = '0;
            found_d     = 1'b0;
            best_lvl_d  = '0;
            quiet_lvl_d = '0;
            best_start_d  = '0;
            quiet_start_d = '0;
            too_long_d  = w_eff > n_eff;
          end else if (job_bad) begin
            rej_d = 1'b1;
          end else begin
            mark_cmd.job_rd = 1'b1;
            if (l_day > 32'(hwm_q)) begin
              hwm_d = CNT_W'(l_day);
            end
          end
        end
      end
      ST_JOB_WR: mark_cmd.job_wr = 1'b1;
      ST_EV_RD: mark_cmd.sweep = 1'b1;
      ST_EV_CALC: begin
        if (too_long_q || 32'(i_q) >= n_eff) begin
          i_d = i_q + CNT_W'(1);
        end else begin
          cov_d = cov_new;
          run_d = (cov_new > end_mark) ? cov_new - end_mark : '0;
        end
      end
      ST_POP: begin
        if (tail_q > head_q && back_val_q <= cov_q) begin
          tail_d   = tail_q - CNT_W'(1);
          dq_re    = 1'b1;
          dq_raddr = ADDR_W'(tail_q - CNT_W'(2));
        end else begin
          dq_we      = 1'b1;
          back_idx_d = i_q[ADDR_W-1:0];
          back_val_d = cov_q;
          if (tail_q == head_q) begin
            front_idx_d = i_q[ADDR_W-1:0];
            front_val_d = cov_q;
          end
          tail_d = tail_q + CNT_W'(1);
        end
      end
      ST_POP_WAIT: begin
        back_idx_d = dq_rdata[ADDR_W+CB-1:CB];
        back_val_d = dq_rdata[CB-1:0];
      end
      ST_HEAD: begin
        if (32'(front_idx_q) + w_eff <= 32'(i_q)) begin
          head_d = head_q + CNT_W'(1);
          if (head_q + CNT_W'(1) == tail_q - CNT_W'(1)) begin
            front_idx_d = back_idx_q;
            front_val_d = back_val_q;
          end else begin
            dq_re    = 1'b1;
            dq_raddr = ADDR_W'(head_q + CNT_W'(1));
          end
        end
      end
      ST_HEAD_WAIT: begin
        front_idx_d = dq_rdata[ADDR_W+CB-1:CB];
        front_val_d = dq_rdata[CB-1:0];
      end
      ST_EVAL: begin
        i_d = i_q + CNT_W'(1);
        if (peak_ok) begin
          found_d = 1'b1;
          if (!found_q) begin
            best_lvl_d    = front_val_q;
            quiet_lvl_d   = front_val_q;
            best_start_d  = DAY_W'(win_start);
            quiet_start_d = DAY_W'(win_start);
          end else begin
            if (front_val_q > best_lvl_q) begin
              best_lvl_d   = front_val_q;
              best_start_d = DAY_W'(win_start);
            end
            if (front_val_q < quiet_lvl_q) begin
              quiet_lvl_d   = front_val_q;
              quiet_start_d = DAY_W'(win_start);
            end
          end
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {rej_q, too_long_q, quiet_out, best_out, quiet_start_q, best_start_q};
          rej_d     = 1'b0;
          hwm_d     = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLR;
      num_days_q    <= DAY_W'(1);
      window_len_q  <= DAY_W'(1);
      i_q           <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      hwm_q         <= '0;
      run_q         <= '0;
      cov_q         <= '0;
      back_idx_q    <= '0;
      back_val_q    <= '0;
      front_idx_q   <= '0;
      front_val_q   <= '0;
      found_q       <= 1'b0;
      too_long_q    <= 1'b0;
      rej_q         <= 1'b0;
      best_lvl_q    <= '0;
      quiet_lvl_q   <= '0;
      best_start_q  <= '0;
      quiet_start_q <= '0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
    end else begin
      state_q       <= state_d;
      num_days_q    <= num_days_d;
      window_len_q  <= window_len_d;
      i_q           <= i_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      hwm_q         <= hwm_d;
      run_q         <= run_d;
      cov_q         <= cov_d;
      back_idx_q    <= back_idx_d;
      back_val_q    <= back_val_d;
      front_idx_q   <= front_idx_d;
      front_val_q   <= front_val_d;
      found_q       <= found_d;
      too_long_q    <= too_long_d;
      rej_q         <= rej_d;
      best_lvl_q    <= best_lvl_d;
      quiet_lvl_q   <= quiet_lvl_d;
      best_start_q  <= best_start_d;
      quiet_start_q <= quiet_start_d;
      m_valid_q     <= m_valid_d;
      m_data_q      <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  wpcs_marks #(
    .DEPTH  (MAX_DAYS),
    .ADDR_W (ADDR_W),
    .CNT_W  (CB)
  ) u_marks (
    .clk_i        (clk_i),
    .cmd_i        (mark_cmd),
    .job_start_i  (job_start_addr),
    .job_end_i    (job_end_addr),
    .sweep_addr_i (i_q[ADDR_W-1:0]),
    .start_o      (start_mark),
    .end_o        (end_mark)
  );

  wpcs_deque #(
    .DEPTH  (MAX_DAYS),
    .ADDR_W (ADDR_W),
    .DATA_W (ADDR_W + CB)
  ) u_deque (
    .clk_i   (clk_i),
    .we_i    (dq_we),
    .waddr_i (dq_waddr),
    .wdata_i (dq_wdata),
    .re_i    (dq_re),
    .raddr_i (dq_raddr),
    .rdata_o (dq_rdata)
  );

endmodule
